[src/mst_pkg.sv]
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants for the interval timer table
// Holds the operation codes, status codes and the slot table port structs.
// ----------------------------------------------------------------------------
package mst_pkg;

   // Operation codes carried in the mode field of a request.
   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_RESTART = 3'd2;
   localparam logic [2:0] MODE_DISABLE = 3'd3;
   localparam logic [2:0] MODE_SETPER  = 3'd4;
   localparam logic [2:0] MODE_SERVICE = 3'd5;

   // Status codes of a result.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // Reset value of the pulse interval register.
   localparam logic [15:0] PULSE_RESET = 16'd50;

   // Most fired slots reported by one service request.
   localparam logic [3:0] MAX_REPORTS = 4'd8;

   // Write controls of one slot table entry.
   typedef struct packed {
      logic        we_period;
      logic        we_start;
      logic        we_en;
      logic        we_rep;
      logic [31:0] period;
      logic [31:0] start;
      logic        en;
      logic        rep;
   } mst_wr_type;

   // Contents of one slot table entry.
   typedef struct packed {
      logic [31:0] period;
      logic [31:0] start;
      logic        en;
      logic        rep;
   } mst_rd_type;

endpackage

[src/mst_req_if.sv]
// ----------------------------------------------------------------------------
// mst_req_if: request channel of the interval timer table
// Valid/ready handshake with the operation fields as payload.
// ----------------------------------------------------------------------------
interface mst_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [2:0]  handle;
   logic [31:0] period;
   logic        enable;
   logic        repeat_req;

   modport source (output valid, output mode, output handle, output period,
                   output enable, output repeat_req, input ready);
   modport sink   (input valid, input mode, input handle, input period,
                   input enable, input repeat_req, output ready);
endinterface

[src/mst_rsp_if.sv]
// ----------------------------------------------------------------------------
// mst_rsp_if: response channel of the interval timer table
// Valid/ready handshake with the result fields as payload.
// ----------------------------------------------------------------------------
interface mst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        fired;
   logic [2:0]  slot;
   logic        pulse;
   logic [31:0] tick_now;
   logic        last;

   modport source (output valid, output status, output fired, output slot,
                   output pulse, output tick_now, output last, input ready);
   modport sink   (input valid, input status, input fired, input slot,
                   input pulse, input tick_now, input last, output ready);
endinterface

[src/multi_slot_interval_timer.sv]
// ----------------------------------------------------------------------------
// multi_slot_interval_timer: table of interval timers on a tick count
// Sequencer, tick and pulse counters, and the response register.
// ----------------------------------------------------------------------------
// Every request except service gives one response: the idle state accepts
// it and the exec state executes it, waiting while the response register
// still holds an earlier response. Service walks the slots in use with a
// single shared subtract and compare unit: after the idle state accepts the
// request and the exec state sets up the scan, a read state registers each
// slot's elapsed time and a check state compares it and updates the slot;
// a flush state then delivers the final response. A fired slot is held
// back until the next fired slot or the final response, so that the final
// response can carry last; the scan stalls only when a held response must go
// out while the response register is full. No new request is accepted until
// the current one is finished, but a request is accepted while its
// predecessor's final response still waits to be taken. The slot table needs
// no clearing pass after reset: only the enable bits are reset, and a slot's
// other fields are always written before it can be enabled.
// ----------------------------------------------------------------------------
module multi_slot_interval_timer #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   mst_req_if.sink     req_chan,
   mst_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import mst_pkg::*;

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   // Latched request.
   logic [2:0]  mode_ff, mode_in;
   logic [2:0]  handle_ff, handle_in;
   logic [31:0] period_ff, period_in;
   logic        enable_ff, enable_in;
   logic        repeat_ff, repeat_in;

   // Counters and configuration.
   logic [31:0]     tick_ff, tick_in;
   logic [15:0]     pcount_ff, pcount_in;
   logic [15:0]     pinterval_ff, pinterval_in;
   logic [CNTW-1:0] used_ff, used_in;

   // Service scan.
   logic [IDXW-1:0] idx_ff, idx_in;
   logic            pend_ff, pend_in;
   logic [2:0]      pend_slot_ff, pend_slot_in;
   logic [3:0]      cnt_ff, cnt_in;

   // Response register.
   logic        rvalid_ff, rvalid_in;
   logic [1:0]  rstatus_ff, rstatus_in;
   logic        rfired_ff, rfired_in;
   logic [2:0]  rslot_ff, rslot_in;
   logic        rpulse_ff, rpulse_in;
   logic [31:0] rtick_ff, rtick_in;
   logic        rlast_ff, rlast_in;

   // Datapath links.
   logic            out_free;
   logic            handle_ok;
   logic [IDXW-1:0] handle_idx;
   logic [IDXW-1:0] wr_idx;
   mst_wr_type      tbl_wr;
   mst_rd_type      tbl_rd;
   logic            alu_load;
   logic            alu_expired;
   logic [31:0]     alu_next_start;
   logic [15:0]     pcount_inc;
   logic            fire;
   logic            emit_held;
   logic            scan_done;
   logic [31:0]     handle_wide;
   logic [31:0]     used_wide;
   logic [31:0]     idx_wide;

   function automatic logic [2:0] slot_field(input logic [31:0] v);
      return v[2:0];
   endfunction

   assign handle_wide = 32'(handle_ff);
   assign used_wide   = 32'(used_ff);
   assign idx_wide    = 32'(idx_ff);
   assign handle_idx  = handle_wide[IDXW-1:0];
   // The count of slots in use never exceeds SLOTS, so this also bounds
   // the handle by the table size.
   assign handle_ok   = handle_wide < used_wide;
   assign out_free    = !rvalid_ff || rsp_chan.ready;
   assign pcount_inc  = pcount_ff + 16'd1;
   assign scan_done   = (idx_wide + 32'd1) >= used_wide;
   assign fire        = tbl_rd.en && alu_expired;
   // A held report goes out when a later slot fires, unless the report
   // limit is already reached, in which case the held one stays the last.
   assign emit_held   = pend_ff && (cnt_ff < MAX_REPORTS);

   mst_slot_table #(
      .SLOTS (SLOTS),
      .IDXW  (IDXW)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .wr_idx (wr_idx),
      .wr     (tbl_wr),
      .rd_idx (idx_ff),
      .rd     (tbl_rd)
   );

   mst_cmp_unit u_cmp (
      .clock      (clock),
      .load       (alu_load),
      .tick       (tick_ff),
      .start      (tbl_rd.start),
      .period     (tbl_rd.period),
      .expired    (alu_expired),
      .next_start (alu_next_start)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      handle_in    = handle_ff;
      period_in    = period_ff;
      enable_in    = enable_ff;
      repeat_in    = repeat_ff;
      tick_in      = tick_ff;
      pcount_in    = pcount_ff;
      pinterval_in = csr_we ? csr_wdata : pinterval_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      cnt_in       = cnt_ff;
      rvalid_in    = rvalid_ff && !rsp_chan.ready;
      rstatus_in   = rstatus_ff;
      rfired_in    = rfired_ff;
      rslot_in     = rslot_ff;
      rpulse_in    = rpulse_ff;
      rtick_in     = rtick_ff;
      rlast_in     = rlast_ff;
      tbl_wr       = '0;
      wr_idx       = idx_ff;
      alu_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in   = req_chan.mode;
               handle_in = req_chan.handle;
               period_in = req_chan.period;
               enable_in = req_chan.enable;
               repeat_in = req_chan.repeat_req;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            if (mode_ff == MODE_SERVICE) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               cnt_in   = '0;
               state_in = (used_ff == '0) ? S_FLUSH : S_SCAN_RD;
            end else if (out_free) begin
               rvalid_in  = 1'b1;
               rstatus_in = ST_OK;
               rfired_in  = 1'b0;
               rslot_in   = 3'd0;
               rpulse_in  = 1'b0;
               rlast_in   = 1'b1;
               rtick_in   = tick_ff;
               state_in   = S_IDLE;
               case (mode_ff) inside
                  MODE_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     rtick_in = tick_ff + 32'd1;
                     if (pcount_inc >= pinterval_ff) begin
                        pcount_in = '0;
                        rpulse_in = 1'b1;
                     end else begin
                        pcount_in = pcount_inc;
                     end
                  end
                  MODE_ADD: begin
                     if (used_wide >= 32'(SLOTS)) begin
                        rstatus_in = ST_FULL;
                     end else begin
                        wr_idx           = used_ff[IDXW-1:0];
                        tbl_wr.we_period = 1'b1;
                        tbl_wr.period    = period_ff;
                        tbl_wr.we_rep    = 1'b1;
                        tbl_wr.rep       = repeat_ff;
                        tbl_wr.we_en     = 1'b1;
                        tbl_wr.en        = enable_ff;
                        tbl_wr.we_start  = enable_ff;
                        tbl_wr.start     = tick_ff;
                        used_in          = used_ff + CNTW'(1);
                        rslot_in         = slot_field(used_wide);
                     end
                  end
                  MODE_RESTART, MODE_DISABLE, MODE_SETPER: begin
                     rslot_in = handle_ff;
                     wr_idx   = handle_idx;
                     if (!handle_ok) begin
                        rstatus_in = ST_BAD;
                     end else if (mode_ff == MODE_RESTART) begin
                        tbl_wr.we_start = 1'b1;
                        tbl_wr.start    = tick_ff;
                        tbl_wr.we_en    = 1'b1;
                        tbl_wr.en       = 1'b1;
                     end else if (mode_ff == MODE_DISABLE) begin
                        tbl_wr.we_en = 1'b1;
                        tbl_wr.en    = 1'b0;
                     end else begin
                        tbl_wr.we_period = 1'b1;
                        tbl_wr.period    = period_ff;
                     end
                  end
                  default: begin
                     // Unused operation codes give a plain ok response.
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            alu_load = 1'b1;
            state_in = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            // Hold the slot when its firing would push out a held report
            // while the response register is still occupied.
            if (!(fire && emit_held && !out_free)) begin
               if (fire) begin
                  tbl_wr.we_en    = 1'b1;
                  tbl_wr.en       = tbl_rd.rep;
                  tbl_wr.we_start = 1'b1;
                  tbl_wr.start    = alu_next_start;
                  if (emit_held) begin
                     rvalid_in  = 1'b1;
                     rstatus_in = ST_OK;
                     rfired_in  = 1'b1;
                     rslot_in   = pend_slot_ff;
                     rpulse_in  = 1'b0;
                     rtick_in   = tick_ff;
                     rlast_in   = 1'b0;
                  end
                  if (cnt_ff < MAX_REPORTS) begin
                     pend_in      = 1'b1;
                     pend_slot_in = slot_field(idx_wide);
                     cnt_in       = cnt_ff + 4'd1;
                  end
               end
               if (scan_done) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + IDXW'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               rvalid_in  = 1'b1;
               rstatus_in = ST_OK;
               rfired_in  = pend_ff;
               rslot_in   = pend_ff ? pend_slot_ff : 3'd0;
               rpulse_in  = 1'b0;
               rtick_in   = tick_ff;
               rlast_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         pcount_ff    <= '0;
         pinterval_ff <= PULSE_RESET;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         pcount_ff    <= pcount_in;
         pinterval_ff <= pinterval_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rvalid_ff    <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      handle_ff    <= handle_in;
      period_ff    <= period_in;
      enable_ff    <= enable_in;
      repeat_ff    <= repeat_in;
      pend_slot_ff <= pend_slot_in;
      rstatus_ff   <= rstatus_in;
      rfired_ff    <= rfired_in;
      rslot_ff     <= rslot_in;
      rpulse_ff    <= rpulse_in;
      rtick_ff     <= rtick_in;
      rlast_ff     <= rlast_in;
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rvalid_ff;
   assign rsp_chan.status   = rstatus_ff;
   assign rsp_chan.fired    = rfired_ff;
   assign rsp_chan.slot     = rslot_ff;
   assign rsp_chan.pulse    = rpulse_ff;
   assign rsp_chan.tick_now = rtick_ff;
   assign rsp_chan.last     = rlast_ff;

endmodule

[src/mst_slot_table.sv]
// ----------------------------------------------------------------------------
// mst_slot_table: per-slot timer storage
// Period, start, enable and repeat for each slot; one write and one read port.
// ----------------------------------------------------------------------------
module mst_slot_table #(
   parameter int SLOTS = 8,
   parameter int IDXW  = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDXW-1:0]     wr_idx,
   input  mst_pkg::mst_wr_type wr,
   input  logic [IDXW-1:0]     rd_idx,
   output mst_pkg::mst_rd_type rd
);
   import mst_pkg::*;

   logic [31:0]      period_ff [SLOTS];
   logic [31:0]      start_ff  [SLOTS];
   logic [SLOTS-1:0] en_ff;
   logic [SLOTS-1:0] rep_ff;

   // Only the enable bits need a reset value; the rest is written before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0;
      end else if (wr.we_en) begin
         en_ff[wr_idx] <= wr.en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we_period) begin
         period_ff[wr_idx] <= wr.period;
      end
      if (wr.we_start) begin
         start_ff[wr_idx] <= wr.start;
      end
      if (wr.we_rep) begin
         rep_ff[wr_idx] <= wr.rep;
      end
   end

   assign rd.period = period_ff[rd_idx];
   assign rd.start  = start_ff[rd_idx];
   assign rd.en     = en_ff[rd_idx];
   assign rd.rep    = rep_ff[rd_idx];

endmodule

[src/mst_cmp_unit.sv]
// ----------------------------------------------------------------------------
// mst_cmp_unit: shared elapsed-time unit
// Registers the modular elapsed time of one slot, then compares it with the
// period and forms the advanced start time.
// ----------------------------------------------------------------------------
module mst_cmp_unit (
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] tick,
   input  logic [31:0] start,
   input  logic [31:0] period,
   output logic        expired,
   output logic [31:0] next_start
);
   logic [31:0] elapsed_ff;
   logic [31:0] elapsed_in;

   assign elapsed_in = tick - start;

   always_ff @(posedge clock) begin
      if (load) begin
         elapsed_ff <= elapsed_in;
      end
   end

   assign expired    = elapsed_ff >= period;
   assign next_start = start + period;

endmodule
